// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/core/aes_cmac_pkg.sv
// shared types, constants and aes round functions for the cmac block
// no dependencies
`timescale 1ns / 1ps
package aes_cmac_pkg;
    localparam int BLK_W = 128;
    localparam int HALF_W = 64;
    localparam int CNT_W = 5;
    localparam int NUM_ROUNDS = 10;
    localparam int RND_W = 4;
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam logic [7:0] GF_RB = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [CNT_W-1:0] FULL_CNT = 5'd16;

    localparam logic [0:0] CFG_KEY_HIGH = 1'b0;
    localparam logic [0:0] CFG_KEY_LOW = 1'b1;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_KEY,
        ENG_RUN
    } eng_state_t;

    typedef enum logic [1:0] {
        JOB_MID,
        JOB_FULL,
        JOB_SHORT
    } job_kind_t;

    typedef struct packed {
        logic [BLK_W-1:0] data;
        job_kind_t kind;
    } job_t;

    typedef struct packed {
        logic busy;
        logic deriving;
    } eng_status_t;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input logic [BLK_W-1:0] b, input int i);
        get_byte = b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic logic [7:0] gmul2(input logic [7:0] b);
        gmul2 = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic [BLK_W-1:0] rk,
                                                   input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [BLK_W-1:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) % 4))];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[BLK_W-1-8*i -: 8] = t[i];
        end
        aes_round = r ^ rk;
    endfunction

    function automatic logic [BLK_W-1:0] next_rkey(input logic [BLK_W-1:0] k,
                                                   input logic [7:0] rcon);
        logic [31:0] w [4];
        logic [31:0] tw;
        logic [BLK_W-1:0] r;
        for (int i = 0; i < 4; i++) begin
            w[i] = k[BLK_W-1-32*i -: 32];
        end
        tw = {SBOX[w[3][23:16]] ^ rcon, SBOX[w[3][15:8]], SBOX[w[3][7:0]],
              SBOX[w[3][31:24]]};
        w[0] = w[0] ^ tw;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        for (int i = 0; i < 4; i++) begin
            r[BLK_W-1-32*i -: 32] = w[i];
        end
        next_rkey = r;
    endfunction

    function automatic logic [BLK_W-1:0] gf_double(input logic [BLK_W-1:0] v);
        gf_double = {v[BLK_W-2:0], 1'b0} ^ {{(BLK_W-8){1'b0}}, (v[BLK_W-1] ? GF_RB : 8'h00)};
    endfunction
endpackage

// File: rtl/core/aes_cmac_front.sv
// front end: accepts message beats, pads short final blocks, queues jobs
// depends on aes_cmac_pkg
`timescale 1ns / 1ps
module aes_cmac_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [63:0]               s_block_high,
    input  logic [63:0]               s_block_low,
    input  logic [4:0]                s_byte_count,
    input  logic                      s_last_block,
    output logic                      job_valid,
    input  logic                      job_ready,
    output aes_cmac_pkg::job_t        job
);
    import aes_cmac_pkg::*;

    job_t q_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0] fill_reg, fill_next;
    logic [BLK_W-1:0] blk, mask, padded;
    job_t in_job;
    logic push, pop;

    // pad: keep bytes below count, 0x80 at count, zeros after
    always_comb begin
        blk = {s_block_high, s_block_low};
        for (int i = 0; i < 16; i++) begin
            mask[BLK_W-1-8*i -: 8] = (i < s_byte_count) ? 8'hff : 8'h00;
            padded[BLK_W-1-8*i -: 8] = (i == s_byte_count) ? PAD_BYTE :
                                       (get_byte(blk, i) & mask[BLK_W-1-8*i -: 8]);
        end
        in_job.data = blk;
        in_job.kind = JOB_MID;
        if (s_last_block) begin
            if (s_byte_count >= FULL_CNT) begin
                in_job.kind = JOB_FULL;
            end else begin
                in_job.kind = JOB_SHORT;
                in_job.data = padded;
            end
        end
    end

    assign s_ready = (fill_reg != QDEPTH[QPTR_W:0]);
    assign push = s_valid && s_ready;
    assign job_valid = (fill_reg != '0);
    assign pop = job_valid && job_ready;
    assign job = q_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        case ({push, pop})
            2'b10: fill_next = fill_reg + 1'b1;
            2'b01: fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= in_job;
    end
endmodule

// File: rtl/core/aes_cmac_engine.sv
// back end: one aes round per cycle, subkey derivation, cbc chaining, tag register
// depends on aes_cmac_pkg
`timescale 1ns / 1ps
module aes_cmac_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_sel,
    input  logic [63:0]               cfg_data,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  aes_cmac_pkg::job_t        job,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [63:0]               m_tag_high,
    output logic [63:0]               m_tag_low,
    output aes_cmac_pkg::eng_status_t status
);
    import aes_cmac_pkg::*;

    eng_state_t state_reg, state_next;
    logic [BLK_W-1:0] key_reg, rk_reg, st_reg, chain_reg, k1_reg, k2_reg, tag_reg;
    logic [7:0] rcon_reg;
    logic [RND_W-1:0] rnd_reg;
    logic ready_keys_reg, final_reg, m_valid_reg;
    logic [BLK_W-1:0] rnd_out, rk_nxt, l_val, sk;
    logic start_job, start_key, round_done, out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign rk_nxt = next_rkey(rk_reg, rcon_reg);
    assign rnd_out = aes_round(st_reg, rk_nxt, rnd_reg == RND_W'(NUM_ROUNDS));
    assign round_done = (rnd_reg == RND_W'(NUM_ROUNDS));
    assign l_val = rnd_out;
    assign sk = (job.kind == JOB_FULL) ? k1_reg : (job.kind == JOB_SHORT) ? k2_reg : '0;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: begin
                if (job_valid && !ready_keys_reg) state_next = ENG_KEY;
                else if (job_valid) state_next = ENG_RUN;
            end
            ENG_KEY: if (round_done) state_next = ENG_IDLE;
            ENG_RUN: begin
                if (round_done && (!final_reg || out_free)) state_next = ENG_IDLE;
            end
            default: state_next = ENG_IDLE;
        endcase
    end

    always_comb begin
        start_key = (state_reg == ENG_IDLE) && job_valid && !ready_keys_reg;
        start_job = (state_reg == ENG_IDLE) && job_valid && ready_keys_reg;
        job_ready = start_job;
        status.busy = (state_reg != ENG_IDLE);
        status.deriving = (state_reg == ENG_KEY);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ENG_IDLE;
            ready_keys_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            chain_reg <= '0;
            key_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ENG_RUN && round_done && final_reg && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                ready_keys_reg <= 1'b0;
                case (cfg_sel)
                    CFG_KEY_HIGH: key_reg[BLK_W-1 -: HALF_W] <= cfg_data;
                    CFG_KEY_LOW: key_reg[HALF_W-1:0] <= cfg_data;
                    default: key_reg <= key_reg;
                endcase
            end
            if (state_reg == ENG_KEY && round_done) ready_keys_reg <= 1'b1;
            if (state_reg == ENG_RUN && round_done) begin
                if (final_reg) begin
                    if (out_free) begin
                        chain_reg <= '0;
                    end
                end else begin
                    chain_reg <= rnd_out;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_key || start_job) begin
            rk_reg <= key_reg;
            rcon_reg <= 8'h01;
            rnd_reg <= RND_W'(1);
            st_reg <= start_key ? key_reg : (chain_reg ^ job.data ^ sk ^ key_reg);
            final_reg <= (job.kind != JOB_MID);
        end else if (status.busy && !round_done) begin
            rk_reg <= rk_nxt;
            rcon_reg <= gmul2(rcon_reg);
            rnd_reg <= rnd_reg + 1'b1;
            st_reg <= rnd_out;
        end
        if (state_reg == ENG_KEY && round_done) begin
            k1_reg <= gf_double(l_val);
            k2_reg <= gf_double(gf_double(l_val));
        end
        if (state_reg == ENG_RUN && round_done && final_reg && out_free) tag_reg <= rnd_out;
    end

    assign m_valid = m_valid_reg;
    assign m_tag_high = tag_reg[BLK_W-1 -: HALF_W];
    assign m_tag_low = tag_reg[HALF_W-1:0];
endmodule

// File: rtl/core/aes_cmac_tag_top.sv
// top level of the aes-128 cmac tag block
// depends on aes_cmac_pkg, aes_cmac_front, aes_cmac_engine, assert_macros.svh
`timescale 1ns / 1ps
// channel | ports                                        | handshake
// input   | s_block_high/low, s_byte_count, s_last_block | s_valid / s_ready
// result  | m_tag_high, m_tag_low                        | m_valid / m_ready
// config  | cfg_we, cfg_index, cfg_data                  | write enable only
// a block passes through the round engine as a start step that loads the state, then ten rounds
// the first block after reset or a key write first waits for subkey derivation
// a final block holds the engine while the previous tag beat is not taken
// a two-entry queue accepts beats while the engine or output stalls, until it is full
// reset is synchronous active low and clears control, chain and key
module aes_cmac_tag_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_block_high,
    input  logic [63:0] s_block_low,
    input  logic [4:0]  s_byte_count,
    input  logic        s_last_block,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_tag_high,
    output logic [63:0] m_tag_low
);
    import aes_cmac_pkg::*;
`include "assert_macros.svh"

    logic job_valid, job_ready;
    job_t job;
    eng_status_t status;

    aes_cmac_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_block_high(s_block_high), .s_block_low(s_block_low),
        .s_byte_count(s_byte_count), .s_last_block(s_last_block),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    aes_cmac_engine u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_sel(cfg_index), .cfg_data(cfg_data),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_tag_high(m_tag_high), .m_tag_low(m_tag_low),
        .status(status)
    );

    `ASSERT_IMPL(a_no_take_busy, aclk, aresetn, job_ready, !status.busy)
    `ASSERT_NEXT(a_busy_after_take, aclk, aresetn, job_ready, status.busy && !status.deriving)
    `ASSERT_IMPL(a_take_needs_job, aclk, aresetn, job_ready, job_valid)
endmodule

// File: verif/aes_cmac_tag_top_test.sv
// self-checking testbench for the aes-128 cmac tag block
// predicts each tag with its own aes and subkey model and checks every output beat
// depends on aes_cmac_pkg and aes_cmac_tag_top
`timescale 1ns / 1ps
module aes_cmac_tag_top_test;
    import aes_cmac_pkg::*;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } tag_t;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [63:0] s_block_high;
    logic [63:0] s_block_low;
    logic [4:0]  s_byte_count;
    logic        s_last_block;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_tag_high;
    logic [63:0] m_tag_low;

    tag_t        pending_tags[$];
    int          errors;
    int          cycles;
    int          blocks_sent;
    bit          calm;

    logic [127:0] key_reg;
    logic [127:0] chain_reg;
    logic [127:0] k1_reg;
    logic [127:0] k2_reg;
    bit           subkeys_valid;

    aes_cmac_tag_top dut (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [7:0] xt(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] aes_encipher(input logic [127:0] key,
                                                  input logic [127:0] pt);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [127:0] rk;
        logic [127:0] x;
        logic [7:0]   rcon;
        logic [31:0]  w0, w1, w2, w3, tw;
        logic [7:0]   a0, a1, a2, a3, al;
        rk = key;
        rcon = 8'h01;
        x = pt ^ key;
        for (int i = 0; i < 16; i++) st[i] = x[127-8*i -: 8];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    sh[i+4*c] = SBOX[st[i+4*((c+i)%4)]];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4*c]; a1 = sh[4*c+1]; a2 = sh[4*c+2]; a3 = sh[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    sh[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
                    sh[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
                    sh[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
                    sh[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
                end
            end
            w3 = rk[31:0];
            tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
            w0 = rk[127:96] ^ tw;
            w1 = rk[95:64] ^ w0;
            w2 = rk[63:32] ^ w1;
            w3 = w3 ^ w2;
            rk = {w0, w1, w2, w3};
            rcon = xt(rcon);
            for (int i = 0; i < 16; i++) st[i] = sh[i] ^ rk[127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) x[127-8*i -: 8] = st[i];
        return x;
    endfunction

    function automatic logic [127:0] gf_dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
    endfunction

    task automatic predict_tag(input logic [127:0] blk, input logic [4:0] cnt,
                               input logic last);
        logic [127:0] m;
        logic [127:0] l;
        tag_t         t;
        if (!subkeys_valid) begin
            l = aes_encipher(key_reg, 128'h0);
            k1_reg = gf_dbl(l);
            k2_reg = gf_dbl(k1_reg);
            subkeys_valid = 1'b1;
        end
        if (!last) begin
            chain_reg = aes_encipher(key_reg, chain_reg ^ blk);
        end else begin
            if (cnt >= 16) begin
                m = blk ^ k1_reg;
            end else begin
                m = blk;
                for (int i = 0; i < 16; i++)
                    if (i >= cnt) m[127-8*i -: 8] = (i == cnt) ? 8'h80 : 8'h00;
                m = m ^ k2_reg;
            end
            {t.hi, t.lo} = aes_encipher(key_reg, chain_reg ^ m);
            pending_tags.push_back(t);
            chain_reg = '0;
        end
    endtask

    task automatic send_block(input logic [127:0] blk, input logic [4:0] cnt,
                              input logic last);
        if (!calm && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_block_high <= blk[127:64];
        s_block_low <= blk[63:0];
        s_byte_count <= cnt;
        s_last_block <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_tag(blk, cnt, last);
        blocks_sent++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_tags.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_KEY_HIGH) key_reg[127:64] = val;
        else key_reg[63:0] = val;
        subkeys_valid = 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_key(input logic [127:0] k);
        write_reg(CFG_KEY_HIGH, k[127:64]);
        write_reg(CFG_KEY_LOW, k[63:0]);
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    task automatic send_message(input int nblk, input logic [4:0] cnt);
        for (int i = 0; i < nblk - 1; i++)
            send_block(rand128(), 5'($urandom_range(0, 31)), 1'b0);
        send_block(rand128(), cnt, 1'b1);
    endtask

    task automatic test_reset_key();
        send_block('0, 5'd0, 1'b1);
        send_block('1, 5'd16, 1'b1);
        settle();
    endtask

    task automatic test_rfc_vectors();
        write_key(128'h2b7e151628aed2a6abf7158809cf4f3c);
        send_block('0, 5'd0, 1'b1);
        send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16, 1'b1);
        send_block(128'h6bc1bee22e409f96e93d7e117393172a, 5'd0, 1'b0);
        send_block(128'hae2d8a571e03ac9c9eb76fac45af8e51, 5'd31, 1'b0);
        send_block(128'h30c81c46a35ce411ffffffffffffffff, 5'd8, 1'b1);
        settle();
    endtask

    task automatic test_field_extremes();
        write_key('1);
        send_block('1, 5'd15, 1'b1);
        send_block('1, 5'd17, 1'b1);
        send_block('1, 5'd31, 1'b1);
        send_block('0, 5'd31, 1'b0);
        send_block('1, 5'd1, 1'b1);
        send_block(rand128(), 5'd0, 1'b0);
        send_block(rand128(), 5'd0, 1'b1);
        settle();
        write_reg(CFG_KEY_HIGH, '0);
        send_block(rand128(), 5'd16, 1'b1);
        settle();
        write_reg(CFG_KEY_LOW, '0);
        send_block(rand128(), 5'd7, 1'b1);
        settle();
    endtask

    task automatic test_steady_stream();
        calm = 1'b1;
        write_key(rand128());
        for (int i = 0; i < 12; i++) send_message($urandom_range(1, 3), 5'($urandom_range(0, 31)));
        settle();
        calm = 1'b0;
    endtask

    task automatic test_random_messages();
        logic [4:0] cnt;
        int         msgs;
        msgs = 0;
        while (blocks_sent < 450) begin
            if (msgs % 25 == 24) begin
                settle();
                case ($urandom_range(3))
                    0: write_key('1);
                    1: write_key('0);
                    2: write_reg(1'($urandom_range(1)), {$urandom, $urandom});
                    default: write_key(rand128());
                endcase
            end
            cnt = ($urandom_range(1) != 0) ? 5'd16 : 5'($urandom_range(0, 31));
            send_message($urandom_range(1, 5), cnt);
            msgs++;
        end
        settle();
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    always @(posedge aclk) begin
        tag_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_tags.size() == 0) begin
                $error("unexpected tag beat %h %h", m_tag_high, m_tag_low);
                errors++;
            end else begin
                want = pending_tags.pop_front();
                if (m_tag_high !== want.hi) begin
                    $error("tag_high expected %h actual %h", want.hi, m_tag_high);
                    errors++;
                end
                if (m_tag_low !== want.lo) begin
                    $error("tag_low expected %h actual %h", want.lo, m_tag_low);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_block_high = '0;
        s_block_low = '0;
        s_byte_count = '0;
        s_last_block = 1'b0;
        m_ready = 1'b0;
        errors = 0;
        cycles = 0;
        blocks_sent = 0;
        calm = 1'b0;
        key_reg = '0;
        chain_reg = '0;
        k1_reg = '0;
        k2_reg = '0;
        subkeys_valid = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_key();
        test_rfc_vectors();
        test_field_extremes();
        test_steady_stream();
        test_random_messages();
        if (pending_tags.size() != 0) errors++;
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
